/* hdl/ils_pkg.sv */
// Shared types and constants for the indexed list store.
// Holds the list size, field widths, mode and status codes, and controller types.
package ils_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int MODE_W   = 3;
    localparam int POS_W    = 5;
    localparam int STAT_W   = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT     = 3'd0,
        MODE_REMOVE     = 3'd1,
        MODE_READ       = 3'd2,
        MODE_WRITE      = 3'd3,
        MODE_REMOVE_ALL = 3'd4,
        MODE_CLEAR      = 3'd5
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_req;
        logic exec;
        logic scan_start;
        logic scan_step;
        logic emit;
    } ils_cmd_t;

    typedef struct packed {
        logic is_remove_all;
        logic scan_done;
        logic out_busy;
    } ils_stat_t;

endpackage

/* hdl/ils_ctrl.sv */
// Controller state machine for the indexed list store.
// Depends on ils_pkg; drives command signals into ils_datapath.
module ils_ctrl
    import ils_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  ils_stat_t stat,
    output ils_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (stat.is_remove_all) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_EMIT: begin
                if (!stat.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/ils_datapath.sv */
// Datapath for the indexed list store: entry cells, count, request and result registers.
// Depends on ils_pkg; steered by ils_ctrl through command and status signals.
module ils_datapath
    import ils_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  ils_cmd_t            cmd,
    output ils_stat_t           stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic [VAL_W-1:0]  ent_reg [CAPACITY];
    logic [VAL_W-1:0]  ent_next [CAPACITY];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  scan_idx_reg;
    logic [CNT_W-1:0]  scan_idx_next;
    logic [MODE_W-1:0] req_mode_reg;
    logic [POS_W-1:0]  req_pos_reg;
    logic [VAL_W-1:0]  req_val_reg;
    logic [STAT_W-1:0] res_status_reg;
    logic [STAT_W-1:0] res_status_next;
    logic [VAL_W-1:0]  res_rd_reg;
    logic [VAL_W-1:0]  res_rd_next;
    logic              out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic [VAL_W-1:0]  rd_data;
    logic              pos_lt_count;
    logic              scan_match;

    assign rd_addr      = cmd.scan_step ? scan_idx_reg[IDX_W-1:0] : req_pos_reg[IDX_W-1:0];
    assign rd_data      = ent_reg[rd_addr];
    assign pos_lt_count = {1'b0, req_pos_reg} < {{(POS_W + 1 - CNT_W){1'b0}}, count_reg};
    assign scan_match   = rd_data == req_val_reg;

    assign stat.is_remove_all = mode_t'(req_mode_reg) == MODE_REMOVE_ALL;
    assign stat.scan_done     = scan_idx_reg >= count_reg;
    assign stat.out_busy      = out_valid_reg && !m_tready;

    always_comb begin
        ent_next        = ent_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        res_status_next = res_status_reg;
        res_rd_next     = res_rd_reg;
        if (cmd.exec) begin
            res_status_next = STAT_OK;
            res_rd_next     = '0;
            case (mode_t'(req_mode_reg))
                MODE_INSERT: begin
                    if ({1'b0, req_pos_reg} > {{(POS_W + 1 - CNT_W){1'b0}}, count_reg}) begin
                        res_status_next = STAT_RANGE;
                    end else if (count_reg == CNT_W'(CAPACITY)) begin
                        res_status_next = STAT_FULL;
                    end else begin
                        for (int j = 1; j < CAPACITY; j++) begin
                            if (POS_W'(j) > req_pos_reg) begin
                                ent_next[j] = ent_reg[j-1];
                            end
                        end
                        ent_next[req_pos_reg[IDX_W-1:0]] = req_val_reg;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_REMOVE: begin
                    if (!pos_lt_count) begin
                        res_status_next = STAT_RANGE;
                    end else begin
                        for (int j = 0; j < CAPACITY - 1; j++) begin
                            if (POS_W'(j) >= req_pos_reg) begin
                                ent_next[j] = ent_reg[j+1];
                            end
                        end
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                MODE_READ: begin
                    if (!pos_lt_count) begin
                        res_status_next = STAT_RANGE;
                    end else begin
                        res_rd_next = rd_data;
                    end
                end
                MODE_WRITE: begin
                    if (!pos_lt_count) begin
                        res_status_next = STAT_RANGE;
                    end else begin
                        ent_next[req_pos_reg[IDX_W-1:0]] = req_val_reg;
                    end
                end
                MODE_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end
        if (cmd.scan_start) begin
            scan_idx_next = '0;
        end
        if (cmd.scan_step) begin
            if (scan_match) begin
                for (int j = 0; j < CAPACITY - 1; j++) begin
                    if (CNT_W'(j) >= scan_idx_reg) begin
                        ent_next[j] = ent_reg[j+1];
                    end
                end
                count_next = count_reg - CNT_W'(1);
            end else begin
                scan_idx_next = scan_idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg        <= ent_next;
        scan_idx_reg   <= scan_idx_next;
        res_status_reg <= res_status_next;
        res_rd_reg     <= res_rd_next;
        if (cmd.load_req) begin
            req_mode_reg <= s_tdata[MODE_W-1:0];
            req_pos_reg  <= s_tdata[MODE_W +: POS_W];
            req_val_reg  <= s_tdata[MODE_W + POS_W +: VAL_W];
        end
        if (cmd.emit) begin
            out_data_reg <= {{(M_DATA_W - STAT_W - VAL_W - CNT_W){1'b0}},
                             count_reg, res_rd_reg, res_status_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> out_valid_reg)
        else $error("result not presented after emit");

    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !(out_valid_reg && !m_tready))
        else $error("result overwritten while stalled");

    a_scan_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan_step && scan_match) |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("matching entry not dropped");

endmodule

/* hdl/indexed_list_store.sv */
// Top level of the indexed list store: stream ports around controller and datapath.
// Depends on ils_pkg, ils_ctrl and ils_datapath.
//
// An ordered list of up to 16 signed 32-bit entries with insert, remove, read, write,
// remove_all and clear requests, one result per request carrying status, read value
// and entry count. A plain request passes from IDLE through EXEC to EMIT, where its result
// is loaded into the output register, and the controller then returns to IDLE for the next;
// remove_all walks the list in SCAN one step per cycle, each step keeping or dropping one entry,
// and goes on to EMIT once the walk reaches the end of the list.
// A new request is accepted only when the previous one has been handed to the output
// register, which lets a finished result wait on m_tready while the next request is
// taken; a result that is still waiting holds the following one in the controller.
module indexed_list_store
    import ils_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // mode[2:0], position[7:3], item_value[39:8]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // status[1:0], read_value[33:2], entry_count[38:34]
);

    ils_cmd_t  cmd;
    ils_stat_t stat;

    ils_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ils_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
